// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_POP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } t_entry;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_REMOVED  = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

endpackage

// ===== hdl/spq_ram.sv =====
`timescale 1ns / 1ps

module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Remove: the front entry is read, then loaded into the result word; an empty queue skips the read.
// Insert: each held entry with a greater priority value is read and moved one place back, then
// the new entry is written in the gap; a refused insert on a full queue goes straight to the result.
// The next word can be taken in the cycle after the result is loaded; a stalled result holds it off.
// One entry memory with a registered read port and one comparator walk the list entry by
// entry. Synchronous active-low reset empties the queue, memory not cleared.
`timescale 1ns / 1ps

module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // value_in [31:0], priority_in [47:32]
    input  logic        s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // value_out [31:0], priority_out [47:32],
                                       // occupancy [52:48], zero [55:53]
    output logic [1:0]  m_axis_tuser   // status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = $bits(spq_pkg::t_entry);

    spq_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_head, n_head, r_tail, n_tail, r_cur, n_cur;
    logic [CW-1:0]   r_count, n_count, r_k, n_k;
    logic            r_cmd, n_cmd;
    logic signed [31:0] r_val, n_val, r_vout, n_vout;
    logic signed [15:0] r_pri, n_pri, r_pout, n_pout;
    logic [1:0]      r_status, n_status;

    logic            r_ovalid, n_ovalid;
    logic [1:0]      r_o_status, n_o_status;
    logic [31:0]     r_o_value, n_o_value;
    logic [15:0]     r_o_prio, n_o_prio;
    logic [4:0]      r_o_occ, n_o_occ;

    logic            w_we, w_re;
    logic [AW-1:0]   w_waddr, w_raddr;
    spq_pkg::t_entry w_wdata, w_rd, w_new;
    logic [EW-1:0]   w_rdata;
    logic [CW+4:0]   w_count_ext;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] x);
        return (x == AW'(DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] x);
        return (x == '0) ? AW'(DEPTH - 1) : x - 1'b1;
    endfunction

    spq_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rd        = spq_pkg::t_entry'(w_rdata);
    assign w_new       = '{value: r_val, prio: r_pri};
    assign w_count_ext = {5'b0, r_count};

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_cur      = r_cur;
        n_count    = r_count;
        n_k        = r_k;
        n_cmd      = r_cmd;
        n_val      = r_val;
        n_pri      = r_pri;
        n_vout     = r_vout;
        n_pout     = r_pout;
        n_status   = r_status;
        n_ovalid   = r_ovalid && !m_axis_tready;
        n_o_status = r_o_status;
        n_o_value  = r_o_value;
        n_o_prio   = r_o_prio;
        n_o_occ    = r_o_occ;
        w_we       = 1'b0;
        w_waddr    = r_cur;
        w_wdata    = w_new;
        w_re       = 1'b0;
        w_raddr    = r_head;

        unique case (r_state)
            spq_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd  = s_axis_tuser;
                    n_val  = s_axis_tdata[31:0];
                    n_pri  = s_axis_tdata[47:32];
                    n_vout = '0;
                    n_pout = '0;
                    if (s_axis_tuser == spq_pkg::CMD_INSERT) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = spq_pkg::STAT_FULL;
                            n_state  = spq_pkg::S_OUT;
                        end else begin
                            n_cur   = r_tail;
                            n_k     = r_count;
                            n_state = spq_pkg::S_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = spq_pkg::STAT_EMPTY;
                            n_state  = spq_pkg::S_OUT;
                        end else begin
                            w_re    = 1'b1;
                            w_raddr = r_head;
                            n_state = spq_pkg::S_POP;
                        end
                    end
                end
            end
            spq_pkg::S_RD: begin
                if (r_k == '0) begin
                    w_we     = 1'b1;
                    n_tail   = f_inc(r_tail);
                    n_count  = r_count + 1'b1;
                    n_status = spq_pkg::STAT_INSERTED;
                    n_state  = spq_pkg::S_OUT;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = f_dec(r_cur);
                    n_state = spq_pkg::S_CMP;
                end
            end
            spq_pkg::S_CMP: begin
                w_we = 1'b1;
                if (w_rd.prio > r_pri) begin
                    w_wdata = w_rd;
                    n_cur   = f_dec(r_cur);
                    n_k     = r_k - 1'b1;
                    n_state = spq_pkg::S_RD;
                end else begin
                    n_tail   = f_inc(r_tail);
                    n_count  = r_count + 1'b1;
                    n_status = spq_pkg::STAT_INSERTED;
                    n_state  = spq_pkg::S_OUT;
                end
            end
            spq_pkg::S_POP: begin
                n_vout   = w_rd.value;
                n_pout   = w_rd.prio;
                n_head   = f_inc(r_head);
                n_count  = r_count - 1'b1;
                n_status = spq_pkg::STAT_REMOVED;
                n_state  = spq_pkg::S_OUT;
            end
            spq_pkg::S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_value  = r_vout;
                    n_o_prio   = r_pout;
                    n_o_occ    = w_count_ext[4:0];
                    n_state    = spq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= spq_pkg::S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_k        <= n_k;
        r_cmd      <= n_cmd;
        r_val      <= n_val;
        r_pri      <= n_pri;
        r_vout     <= n_vout;
        r_pout     <= n_pout;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_value  <= n_o_value;
        r_o_prio   <= n_o_prio;
        r_o_occ    <= n_o_occ;
    end

    assign s_axis_tready = (r_state == spq_pkg::S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, r_o_occ, r_o_prio, r_o_value};
    assign m_axis_tuser  = r_o_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue occupancy exceeds its depth");

    a_cmp_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == spq_pkg::S_CMP |-> r_k != '0)
        else $error("comparison started with no entry left to move");

    a_pop_is_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == spq_pkg::S_POP |-> (r_cmd == spq_pkg::CMD_REMOVE && r_count != '0))
        else $error("front entry read without a remove on a non-empty queue");

    a_tail_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == spq_pkg::S_IDLE |->
            ((int'(r_head) + int'(r_count)) == int'(r_tail)
             || (int'(r_head) + int'(r_count)) == int'(r_tail) + DEPTH))
        else $error("tail pointer out of step with head and occupancy");

endmodule

// ===== dv/sorted_priority_queue_tb.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

    localparam int DEPTH       = 16;
    localparam int N_RANDOM    = 1275;
    localparam int END_CYCLES  = 64;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } t_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic signed [15:0] prio;
        logic [4:0]         occupancy;
    } t_word;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;  // value_in [31:0], priority_in [47:32]
    logic        s_axis_tuser  = 1'b0;  // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;  // value_out [31:0], priority_out [47:32], occupancy [52:48]
    logic [1:0]  m_axis_tuser;  // status
    logic        hold_off      = 1'b0;

    t_item           pending_items[$];
    t_word           expected_words[$];
    spq_pkg::t_entry shadow_list[DEPTH];
    int              shadow_count;
    int              gen_count;
    int              n_items;
    int              items_sent;
    int              words_checked;
    int              mismatches;
    int              tx_gap;
    int              rx_gap;
    int              peak_count;
    int              status_hits[4];
    t_item           next_item;

    always #2 i_clk = ~i_clk;

    sorted_priority_queue #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    function automatic int draw_gap(input int seq);
        if (((seq / 40) % 4) == 3)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t ns word %0d: %s got %0h, expected %0h",
                 $realtime, words_checked, what, got, want);
    endtask

    // Places or serves one entry in the shadow list and queues the word that
    // the block should return for it.
    task automatic place_or_serve(input t_item it);
        t_word w;
        int    pos;
        int    i;
        w = '0;
        if (it.cmd == spq_pkg::CMD_INSERT) begin
            if (shadow_count >= DEPTH) begin
                w.status = spq_pkg::STAT_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_list[pos].prio <= it.prio)
                    pos++;
                for (i = shadow_count; i > pos; i--)
                    shadow_list[i] = shadow_list[i - 1];
                shadow_list[pos].value = it.value;
                shadow_list[pos].prio  = it.prio;
                shadow_count++;
                w.status = spq_pkg::STAT_INSERTED;
            end
        end else begin
            if (shadow_count == 0) begin
                w.status = spq_pkg::STAT_EMPTY;
            end else begin
                w.value = shadow_list[0].value;
                w.prio  = shadow_list[0].prio;
                for (i = 1; i < shadow_count; i++)
                    shadow_list[i - 1] = shadow_list[i];
                shadow_count--;
                w.status = spq_pkg::STAT_REMOVED;
            end
        end
        w.occupancy = shadow_count[4:0];
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        status_hits[w.status]++;
        expected_words.push_back(w);
    endtask

    task automatic queue_item(input logic cmd, input logic [31:0] value,
                              input logic [15:0] prio);
        t_item it;
        it.cmd   = cmd;
        it.value = value;
        it.prio  = prio;
        pending_items.push_back(it);
        if (cmd == spq_pkg::CMD_INSERT && gen_count < DEPTH)
            gen_count++;
        else if (cmd == spq_pkg::CMD_REMOVE && gen_count > 0)
            gen_count--;
    endtask

    function automatic logic [15:0] pick_prio();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return 16'($signed($urandom_range(0, 8)) - 4);
        if (sel < 70)
            return 16'($urandom);
        if (sel < 85) begin
            case ($urandom_range(0, 6))
                0: return 16'h8000;
                1: return 16'h8001;
                2: return 16'hFFFF;
                3: return 16'h0000;
                4: return 16'h0001;
                5: return 16'h7FFE;
                default: return 16'h7FFF;
            endcase
        end
        return 16'($urandom_range(0, 15));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                next_item.cmd   = s_axis_tuser;
                next_item.value = s_axis_tdata[31:0];
                next_item.prio  = s_axis_tdata[47:32];
                place_or_serve(next_item);
                items_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    next_item = pending_items.pop_front();
                    s_axis_tdata  <= {next_item.prio, next_item.value};
                    s_axis_tuser  <= next_item.cmd;
                    s_axis_tvalid <= 1'b1;
                    tx_gap = draw_gap(items_sent);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("word with nothing expected", m_axis_tdata[31:0], 32'd0);
                end else begin
                    t_word w;
                    w = expected_words.pop_front();
                    if (m_axis_tuser !== w.status)
                        report_mismatch("status", 32'(m_axis_tuser), 32'(w.status));
                    if (m_axis_tdata[31:0] !== w.value)
                        report_mismatch("value", m_axis_tdata[31:0], w.value);
                    if (m_axis_tdata[47:32] !== w.prio)
                        report_mismatch("priority", {16'h0000, m_axis_tdata[47:32]},
                                        {16'h0000, w.prio});
                    if (m_axis_tdata[52:48] !== w.occupancy)
                        report_mismatch("occupancy", 32'(m_axis_tdata[52:48]),
                                        32'(w.occupancy));
                    if (m_axis_tdata[55:53] !== 3'b000)
                        report_mismatch("padding", 32'(m_axis_tdata[55:53]), 32'd0);
                end
                words_checked++;
                rx_gap = draw_gap(words_checked);
            end
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // The receiver stops for a long stretch twice so that the block backs up.
    initial begin
        while (items_sent < 200)
            @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
        while (items_sent < 800)
            @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (150) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d words outstanding.", expected_words.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [15:0] dir_prio[16];
        int          phase;
        int          phase_left;
        int          k;
        int          chance;

        dir_prio = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0005, 16'hFFFF,
                     16'h7FFF, 16'h8000, 16'h0064, 16'h0064, 16'hFF9C, 16'h0001,
                     16'h0001, 16'h0007, 16'h0000, 16'h7FFE};
        gen_count = 0;

        queue_item(spq_pkg::CMD_REMOVE, $urandom, 16'($urandom));
        for (k = 0; k < 16; k++) begin
            case (k)
                0: queue_item(spq_pkg::CMD_INSERT, 32'h7FFF_FFFF, dir_prio[k]);
                1: queue_item(spq_pkg::CMD_INSERT, 32'h8000_0000, dir_prio[k]);
                2: queue_item(spq_pkg::CMD_INSERT, 32'h0000_0000, dir_prio[k]);
                3: queue_item(spq_pkg::CMD_INSERT, 32'hFFFF_FFFF, dir_prio[k]);
                4: queue_item(spq_pkg::CMD_INSERT, 32'hAAAA_AAAA, dir_prio[k]);
                5: queue_item(spq_pkg::CMD_INSERT, 32'h5555_5555, dir_prio[k]);
                default: queue_item(spq_pkg::CMD_INSERT, 32'h100 + k, dir_prio[k]);
            endcase
        end
        queue_item(spq_pkg::CMD_INSERT, 32'hDEAD_0001, 16'h8000);
        for (k = 0; k < 7; k++)
            queue_item(spq_pkg::CMD_REMOVE, $urandom, 16'($urandom));

        phase      = 2;
        phase_left = 0;
        for (k = 0; k < N_RANDOM; k++) begin
            if (phase_left == 0) begin
                phase      = $urandom_range(0, 2);
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            chance = (phase == 0) ? 80 : (phase == 1) ? 20 : 50;
            if ($urandom_range(0, 99) < chance)
                queue_item(spq_pkg::CMD_INSERT, pick_value(), pick_prio());
            else
                queue_item(spq_pkg::CMD_REMOVE, $urandom, 16'($urandom));
        end
        n_items = pending_items.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_sent < n_items)
            @(posedge i_clk);
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Ran %0d items: %0d inserts placed, %0d removes served, peak occupancy %0d.",
                 items_sent, status_hits[spq_pkg::STAT_INSERTED],
                 status_hits[spq_pkg::STAT_REMOVED], peak_count);
        $display("Empty removes %0d, refused inserts %0d, words checked %0d, mismatches %0d.",
                 status_hits[spq_pkg::STAT_EMPTY], status_hits[spq_pkg::STAT_FULL],
                 words_checked, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
